// File: hdl/lli_pkg.sv
package lli_pkg;

  localparam int MAG_W = 66;
  localparam int Q_W = 32;

  typedef struct packed {
    logic par;
    logic neg;
    logic [MAG_W-1:0] dmag;
    logic [MAG_W-1:0] nmag;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [32:0] ux;
    logic signed [32:0] uy;
  } lli_job_t;

  typedef struct packed {
    logic par;
    logic neg;
    logic ovf;
    logic [MAG_W-1:0] dmag;
    logic [MAG_W-1:0] rem;
    logic [Q_W-1:0] low;
    logic [Q_W-1:0] q;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [32:0] ux;
    logic signed [32:0] uy;
  } lli_div_t;

  typedef struct packed {
    logic intersects;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] param_t;
  } lli_res_t;

endpackage

// File: hdl/lli_fifo.sv
module lli_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// File: hdl/lli_front.sv
module lli_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic               kind,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by,
  input  logic signed [31:0] cx,
  input  logic signed [31:0] cy,
  input  logic signed [31:0] dx,
  input  logic signed [31:0] dy,
  output logic               job_valid,
  output lli_pkg::lli_job_t  job
);

  // stage 1: directions and offset
  logic v1;
  logic signed [32:0] ux1, uy1, vx1, vy1, wx1, wy1;
  logic signed [31:0] ax1, ay1;
  // stage 2: products
  logic v2;
  logic signed [65:0] p0, p1, p2, p3;
  logic signed [32:0] ux2, uy2;
  logic signed [31:0] ax2, ay2;
  // stage 3: cross products
  logic v3;
  logic signed [66:0] d3, n3;
  logic signed [32:0] ux3, uy3;
  logic signed [31:0] ax3, ay3;
  // stage 4: classify
  logic signed [66:0] dabs, nabs;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      job_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      job_valid <= v3;
    end
  end

  assign dabs = d3[66] ? -d3 : d3;
  assign nabs = n3[66] ? -n3 : n3;

  always_ff @(posedge clk) begin
    if (en) begin
      ux1 <= kind ? 33'(bx) : 33'(bx) - 33'(ax);
      uy1 <= kind ? 33'(by) : 33'(by) - 33'(ay);
      vx1 <= kind ? 33'(dx) : 33'(dx) - 33'(cx);
      vy1 <= kind ? 33'(dy) : 33'(dy) - 33'(cy);
      wx1 <= 33'(cx) - 33'(ax);
      wy1 <= 33'(cy) - 33'(ay);
      ax1 <= ax;
      ay1 <= ay;

      p0 <= ux1 * vy1;
      p1 <= vx1 * uy1;
      p2 <= wx1 * vy1;
      p3 <= wy1 * vx1;
      ux2 <= ux1;
      uy2 <= uy1;
      ax2 <= ax1;
      ay2 <= ay1;

      d3 <= 67'(p0) - 67'(p1);
      n3 <= 67'(p2) - 67'(p3);
      ux3 <= ux2;
      uy3 <= uy2;
      ax3 <= ax2;
      ay3 <= ay2;

      job.par <= (d3 == '0);
      job.neg <= d3[66] ^ n3[66];
      job.dmag <= dabs[65:0];
      job.nmag <= nabs[65:0];
      job.ax <= ax3;
      job.ay <= ay3;
      job.ux <= ux3;
      job.uy <= uy3;
    end
  end

endmodule

// File: hdl/lli_back.sv
module lli_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              job_valid,
  input  lli_pkg::lli_job_t job,
  output logic              res_valid,
  output lli_pkg::lli_res_t res
);

  localparam int NW = lli_pkg::MAG_W + FRAC_BITS;
  localparam logic signed [64:0] BIAS = (65'sd1 <<< FRAC_BITS) - 65'sd1;

  lli_pkg::lli_div_t st [lli_pkg::Q_W+1];
  logic sv [lli_pkg::Q_W+1];

  logic [NW-1:0] nf;
  logic [lli_pkg::MAG_W-1:0] hi;

  assign nf = {job.nmag, {FRAC_BITS{1'b0}}};
  assign hi = lli_pkg::MAG_W'(nf[NW-1:lli_pkg::Q_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].par <= job.par;
      st[0].neg <= job.neg;
      st[0].ovf <= (hi >= job.dmag);
      st[0].dmag <= job.dmag;
      st[0].rem <= hi;
      st[0].low <= nf[lli_pkg::Q_W-1:0];
      st[0].q <= '0;
      st[0].ax <= job.ax;
      st[0].ay <= job.ay;
      st[0].ux <= job.ux;
      st[0].uy <= job.uy;
    end
  end

  for (genvar k = 1; k <= lli_pkg::Q_W; k++) begin : g_div
    logic [lli_pkg::MAG_W:0] trial;
    logic ge;

    assign trial = {st[k-1].rem, st[k-1].low[lli_pkg::Q_W-1]} - {1'b0, st[k-1].dmag};
    assign ge = !trial[lli_pkg::MAG_W];

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k] <= 1'b0;
      end else if (en) begin
        sv[k] <= sv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k].par <= st[k-1].par;
        st[k].neg <= st[k-1].neg;
        st[k].ovf <= st[k-1].ovf;
        st[k].dmag <= st[k-1].dmag;
        st[k].rem <= ge ? trial[lli_pkg::MAG_W-1:0]
                        : {st[k-1].rem[lli_pkg::MAG_W-2:0], st[k-1].low[lli_pkg::Q_W-1]};
        st[k].low <= {st[k-1].low[lli_pkg::Q_W-2:0], 1'b0};
        st[k].q <= {st[k-1].q[lli_pkg::Q_W-2:0], ge};
        st[k].ax <= st[k-1].ax;
        st[k].ay <= st[k-1].ay;
        st[k].ux <= st[k-1].ux;
        st[k].uy <= st[k-1].uy;
      end
    end
  end

  // saturate t
  logic [31:0] limit, tmag;
  logic vt;
  logic par_t;
  logic signed [31:0] t_t, ax_t, ay_t;
  logic signed [32:0] ux_t, uy_t;

  assign limit = st[lli_pkg::Q_W].neg ? 32'h8000_0000 : 32'h7fff_ffff;
  assign tmag = (st[lli_pkg::Q_W].ovf || (st[lli_pkg::Q_W].q > limit))
              ? limit : st[lli_pkg::Q_W].q;

  // products
  logic vm;
  logic par_m;
  logic signed [64:0] prx, pry;
  logic signed [31:0] t_m, ax_m, ay_m;

  // coordinates
  logic signed [64:0] shx, shy;
  logic signed [65:0] sx, sy;
  logic [31:0] px, py;

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
      vm <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      vt <= sv[lli_pkg::Q_W];
      vm <= vt;
      res_valid <= vm;
    end
  end

  assign shx = (prx + (prx[64] ? BIAS : 65'sd0)) >>> FRAC_BITS;
  assign shy = (pry + (pry[64] ? BIAS : 65'sd0)) >>> FRAC_BITS;
  assign sx = 66'(ax_m) + 66'(shx);
  assign sy = 66'(ay_m) + 66'(shy);

  always_comb begin
    if (sx > 66'sd2147483647) begin
      px = 32'h7fff_ffff;
    end else if (sx < -66'sd2147483648) begin
      px = 32'h8000_0000;
    end else begin
      px = sx[31:0];
    end
    if (sy > 66'sd2147483647) begin
      py = 32'h7fff_ffff;
    end else if (sy < -66'sd2147483648) begin
      py = 32'h8000_0000;
    end else begin
      py = sy[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      par_t <= st[lli_pkg::Q_W].par;
      t_t <= st[lli_pkg::Q_W].par ? 32'sd0
           : (st[lli_pkg::Q_W].neg ? -$signed(tmag) : $signed(tmag));
      ax_t <= st[lli_pkg::Q_W].ax;
      ay_t <= st[lli_pkg::Q_W].ay;
      ux_t <= st[lli_pkg::Q_W].ux;
      uy_t <= st[lli_pkg::Q_W].uy;

      par_m <= par_t;
      prx <= t_t * ux_t;
      pry <= t_t * uy_t;
      t_m <= t_t;
      ax_m <= ax_t;
      ay_m <= ay_t;

      res.intersects <= !par_m;
      res.point_x <= par_m ? 32'd0 : px;
      res.point_y <= par_m ? 32'd0 : py;
      res.param_t <= t_m;
    end
  end

endmodule

// File: hdl/line_line_intersect_2d.sv
// two-line intersection in the plane on signed 32-bit coordinates; param_t is
// signed fixed point with FRAC_BITS fraction bits
// input channel: push/full; a beat carries kind, A, B (or first direction),
// C and D (or second direction)
// result channel: empty/pop; the oldest result sits on intersects, point_x,
// point_y and param_t while empty is low
// every input beat yields exactly one result beat, in order
// throughput: one beat per cycle while full is low; a beat passes through
// 4 front stages (differences, products, cross products, classify), the
// mid queue, 33 stages of the pipelined restoring divider (a load stage,
// then one quotient bit per stage) and 3 stages for saturation, coordinate
// products and rounding, then the result queue
// reset clears the pipelines and both queues; no results are pending after it
// when pop is held low the result queue fills, the back pipeline halts, the
// mid queue fills behind it and then full rises; nothing is dropped
module line_line_intersect_2d #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               kind,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by,
  input  logic signed [31:0] cx,
  input  logic signed [31:0] cy,
  input  logic signed [31:0] dx,
  input  logic signed [31:0] dy,
  output logic               empty,
  input  logic               pop,
  output logic               intersects,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] param_t
);

  localparam int JW = $bits(lli_pkg::lli_job_t);
  localparam int RW = $bits(lli_pkg::lli_res_t);

  logic fe, be;
  logic mfull, mempty, ofull;
  logic job_valid, res_valid;
  lli_pkg::lli_job_t fjob, bjob;
  lli_pkg::lli_res_t res, ores;
  logic [JW-1:0] mq_rd;
  logic [RW-1:0] oq_rd;

  assign fe = !mfull;
  assign be = !ofull;
  assign full = !fe;

  lli_front u_front (
    .clk(clk), .rst(rst), .en(fe), .in_valid(push && fe), .kind(kind),
    .ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy), .dx(dx), .dy(dy),
    .job_valid(job_valid), .job(fjob)
  );

  lli_fifo #(.WIDTH(JW), .DEPTH(4)) u_midq (
    .clk(clk), .rst(rst), .push(job_valid && fe), .wdata(fjob),
    .pop(be), .rdata(mq_rd), .full(mfull), .empty(mempty)
  );

  assign bjob = mq_rd;

  lli_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .en(be), .job_valid(!mempty), .job(bjob),
    .res_valid(res_valid), .res(res)
  );

  lli_fifo #(.WIDTH(RW), .DEPTH(2)) u_outq (
    .clk(clk), .rst(rst), .push(res_valid && be), .wdata(res),
    .pop(pop), .rdata(oq_rd), .full(ofull), .empty(empty)
  );

  assign ores = oq_rd;
  assign intersects = ores.intersects;
  assign point_x = ores.point_x;
  assign point_y = ores.point_y;
  assign param_t = ores.param_t;

endmodule

// File: tb/tb_line_line_intersect_2d.sv
`timescale 1ns / 100ps
module tb_line_line_intersect_2d;
  localparam int FRAC = 16;
  localparam logic signed [63:0] MAXQ = 64'sd2147483647;
  localparam logic signed [63:0] MINQ = -64'sd2147483648;

  typedef struct {
    logic kind;
    logic signed [31:0] ax, ay, bx, by, cx, cy, dx, dy;
  } query_t;

  typedef struct {
    logic hit;
    logic signed [31:0] px, py, t;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic full;
  logic kind = 0;
  logic signed [31:0] ax = 0, ay = 0, bx = 0, by = 0, cx = 0, cy = 0, dx = 0, dy = 0;
  logic empty;
  logic pop = 0;
  logic intersects;
  logic signed [31:0] point_x, point_y, param_t;

  answer_t answers_due[$];
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  int mismatches = 0;
  int beats_out = 0;
  int beats_in = 0;
  int parallel_seen = 0;
  int sat_seen = 0;

  line_line_intersect_2d #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind),
    .ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy), .dx(dx), .dy(dy),
    .empty(empty), .pop(pop), .intersects(intersects),
    .point_x(point_x), .point_y(point_y), .param_t(param_t)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic logic signed [63:0] clamp_q(logic signed [127:0] v);
    if (v > 128'(MAXQ)) return MAXQ;
    if (v < 128'(MINQ)) return MINQ;
    return v[63:0];
  endfunction

  function automatic answer_t intersect_lines(query_t q);
    answer_t r;
    logic signed [127:0] ux, uy, vx, vy, den, num, tq, prod, sum;
    logic signed [63:0] t;
    ux = q.kind ? 128'(q.bx) : 128'(q.bx) - 128'(q.ax);
    uy = q.kind ? 128'(q.by) : 128'(q.by) - 128'(q.ay);
    vx = q.kind ? 128'(q.dx) : 128'(q.dx) - 128'(q.cx);
    vy = q.kind ? 128'(q.dy) : 128'(q.dy) - 128'(q.cy);
    den = ux * vy - vx * uy;
    r = '{0, 0, 0, 0};
    if (den == 0) return r;
    num = (128'(q.cx) - 128'(q.ax)) * vy - (128'(q.cy) - 128'(q.ay)) * vx;
    tq = (num <<< FRAC) / den;
    t = clamp_q(tq);
    prod = 128'(t) * ux;
    sum = 128'(q.ax) + prod / (128'sd1 <<< FRAC);
    r.px = clamp_q(sum);
    prod = 128'(t) * uy;
    sum = 128'(q.ay) + prod / (128'sd1 <<< FRAC);
    r.py = clamp_q(sum);
    r.t = t;
    r.hit = 1;
    return r;
  endfunction

  task automatic send_query(query_t q);
    answer_t a;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      push <= 0;
      @(negedge clk);
    end
    kind <= q.kind; ax <= q.ax; ay <= q.ay; bx <= q.bx; by <= q.by;
    cx <= q.cx; cy <= q.cy; dx <= q.dx; dy <= q.dy;
    push <= 1;
    @(posedge clk);
    while (full) @(posedge clk);
    a = intersect_lines(q);
    answers_due.push_back(a);
    beats_in++;
    if (!a.hit) parallel_seen++;
    else if (a.t == 32'h7fffffff || a.t == 32'h80000000) sat_seen++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      pop <= 0;
    end else begin
      pop <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    answer_t e;
    if (!rst && pop && !empty) begin
      beats_out++;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %0d", beats_out);
      end else begin
        e = answers_due.pop_front();
        if (intersects !== e.hit || point_x !== e.px || point_y !== e.py ||
            param_t !== e.t) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: exp %b %h %h %h got %b %h %h %h", beats_out,
                     e.hit, e.px, e.py, e.t, intersects, point_x, point_y, param_t);
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $signed($urandom_range(2000)) - 1000;
      2: return ($signed($urandom_range(200)) - 100) <<< FRAC;
      3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(65535 * 8)) - 65535 * 4;
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    q.kind = $urandom_range(1);
    q.ax = rand_coord(); q.ay = rand_coord(); q.bx = rand_coord(); q.by = rand_coord();
    q.cx = rand_coord(); q.cy = rand_coord(); q.dx = rand_coord(); q.dy = rand_coord();
    if ($urandom_range(9) == 0) begin
      // force parallel lines
      if (q.kind) begin
        q.dx = q.bx; q.dy = q.by;
      end else begin
        q.dx = q.cx + (q.bx - q.ax); q.dy = q.cy + (q.by - q.ay);
      end
    end
    return q;
  endfunction

  task automatic wait_drained();
    push <= 0;
    while (answers_due.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic test_directed();
    query_t q;
    logic signed [31:0] ext[4] = '{32'h7fffffff, 32'h80000000, 0, -1};
    // crossing lines
    q = '{1, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000};
    send_query(q);
    q = '{0, 0, 0, 32'h20000, 32'h20000, 0, 32'h20000, 32'h20000, 0};
    send_query(q);
    // parallel, coincident, degenerate
    q = '{1, 5, 7, 3, 4, 9, 1, 6, 8}; send_query(q);
    q = '{0, 1, 1, 1, 1, 3, 3, 3, 3}; send_query(q);
    q = '{0, 0, 0, 1, 1, 2, 2, 3, 3}; send_query(q);
    // saturating parameter
    q = '{1, 0, 0, 1, 0, 32'h7fffffff, 0, 1, 1}; send_query(q);
    q = '{1, 0, 0, 1, 0, 32'h80000000, 0, 1, 1}; send_query(q);
    for (int i = 0; i < 16; i++) begin
      q.kind = i[0];
      q.ax = ext[i % 4]; q.ay = ext[(i + 1) % 4]; q.bx = ext[(i + 2) % 4];
      q.by = ext[(i / 4) % 4]; q.cx = ext[(i + 3) % 4]; q.cy = ext[i / 4];
      q.dx = ext[(i / 2) % 4]; q.dy = ext[(i + i / 4) % 4];
      send_query(q);
    end
    wait_drained();
  endtask

  task automatic test_random(int n, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (n) send_query(rand_query());
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    hold_cycles = 300;
    repeat (120) send_query(rand_query());
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_random(450, 15, 84);
    test_random(450, 84, 15);
    test_backpressure();
    test_random(400, 0, 0);
    $display("sent %0d queries, checked %0d results", beats_in, beats_out);
    $display("parallel cases %0d, saturated parameter cases %0d", parallel_seen, sat_seen);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end
endmodule
